>>> hdl/mglyph_pkg.sv
// Shared types, codepoint ranges and glyph tables for the mosaic glyph pixel generator.
package mglyph_pkg;

    // Codepoint ranges of the three glyph sets.
    localparam logic [20:0] SEXT_FIRST  = 21'h1FB00;
    localparam logic [20:0] SEXT_LAST   = 21'h1FB3B;
    localparam logic [20:0] BLOCK_FIRST = 21'h02580;
    localparam logic [20:0] BLOCK_LAST  = 21'h0259F;
    localparam logic [20:0] BOX_FIRST   = 21'h02500;
    localparam logic [20:0] BOX_LAST    = 21'h0257F;

    // Sextant masks that have no codepoint of their own.
    localparam logic [6:0] SEXT_SKIP_LO = 7'd21;
    localparam logic [6:0] SEXT_SKIP_HI = 7'd42;

    // Weight of one box drawing arm.
    typedef enum logic [1:0] {
        ARM_NONE,
        ARM_LIGHT,
        ARM_HEAVY
    } arm_weight_t;

    // Arm set of one box drawing character.
    typedef struct packed {
        logic        found;
        arm_weight_t up;
        arm_weight_t down;
        arm_weight_t left;
        arm_weight_t right;
    } box_arms_t;

    // Block element codes, as offsets from the start of the block range.
    typedef enum logic [4:0] {
        BLK_UPPER_HALF   = 5'h00,
        BLK_LOWER_1_8    = 5'h01,
        BLK_LOWER_1_4    = 5'h02,
        BLK_LOWER_3_8    = 5'h03,
        BLK_LOWER_HALF   = 5'h04,
        BLK_LOWER_5_8    = 5'h05,
        BLK_LOWER_3_4    = 5'h06,
        BLK_LOWER_7_8    = 5'h07,
        BLK_FULL         = 5'h08,
        BLK_LEFT_7_8     = 5'h09,
        BLK_LEFT_3_4     = 5'h0A,
        BLK_LEFT_5_8     = 5'h0B,
        BLK_LEFT_HALF    = 5'h0C,
        BLK_LEFT_3_8     = 5'h0D,
        BLK_LEFT_1_4     = 5'h0E,
        BLK_LEFT_1_8     = 5'h0F,
        BLK_RIGHT_HALF   = 5'h10,
        BLK_SHADE_LIGHT  = 5'h11,
        BLK_SHADE_MEDIUM = 5'h12,
        BLK_SHADE_DARK   = 5'h13,
        BLK_UPPER_1_8    = 5'h14,
        BLK_RIGHT_1_8    = 5'h15,
        BLK_QUAD_LL      = 5'h16,
        BLK_QUAD_LR      = 5'h17,
        BLK_QUAD_UL      = 5'h18,
        BLK_QUAD_UL_LL_LR = 5'h19,
        BLK_QUAD_UL_LR   = 5'h1A,
        BLK_QUAD_UL_UR_LL = 5'h1B,
        BLK_QUAD_UL_UR_LR = 5'h1C,
        BLK_QUAD_UR      = 5'h1D,
        BLK_QUAD_UR_LL   = 5'h1E,
        BLK_QUAD_UR_LL_LR = 5'h1F
    } blk_code_t;

    // Quadrant mask bits: upper left, upper right, lower left, lower right.
    localparam logic [3:0] QUAD_UL = 4'b0001;
    localparam logic [3:0] QUAD_UR = 4'b0010;
    localparam logic [3:0] QUAD_LL = 4'b0100;
    localparam logic [3:0] QUAD_LR = 4'b1000;

    // 2x2 ordered dither matrix, indexed [row][column].
    localparam logic [1:0] BAYER2 [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

    // Box drawing table, keyed by the codepoint offset from the range start.
    function automatic box_arms_t box_lookup(input logic [6:0] lo);
        box_arms_t a;
        a = '{found: 1'b1, up: ARM_NONE, down: ARM_NONE, left: ARM_NONE, right: ARM_NONE};
        unique case (lo)
            7'h00: begin a.left = ARM_LIGHT; a.right = ARM_LIGHT; end
            7'h02: begin a.up = ARM_LIGHT; a.down = ARM_LIGHT; end
            7'h0C: begin a.down = ARM_LIGHT; a.right = ARM_LIGHT; end
            7'h10: begin a.down = ARM_LIGHT; a.left = ARM_LIGHT; end
            7'h14: begin a.up = ARM_LIGHT; a.right = ARM_LIGHT; end
            7'h18: begin a.up = ARM_LIGHT; a.left = ARM_LIGHT; end
            7'h1C: begin a.up = ARM_LIGHT; a.down = ARM_LIGHT; a.right = ARM_LIGHT; end
            7'h24: begin a.up = ARM_LIGHT; a.down = ARM_LIGHT; a.left = ARM_LIGHT; end
            7'h2C: begin a.down = ARM_LIGHT; a.left = ARM_LIGHT; a.right = ARM_LIGHT; end
            7'h34: begin a.up = ARM_LIGHT; a.left = ARM_LIGHT; a.right = ARM_LIGHT; end
            7'h3C:
            begin
                a.up = ARM_LIGHT; a.down = ARM_LIGHT;
                a.left = ARM_LIGHT; a.right = ARM_LIGHT;
            end
            7'h01: begin a.left = ARM_HEAVY; a.right = ARM_HEAVY; end
            7'h03: begin a.up = ARM_HEAVY; a.down = ARM_HEAVY; end
            7'h0F: begin a.down = ARM_HEAVY; a.right = ARM_HEAVY; end
            7'h13: begin a.down = ARM_HEAVY; a.left = ARM_HEAVY; end
            7'h17: begin a.up = ARM_HEAVY; a.right = ARM_HEAVY; end
            7'h1B: begin a.up = ARM_HEAVY; a.left = ARM_HEAVY; end
            7'h23: begin a.up = ARM_HEAVY; a.down = ARM_HEAVY; a.right = ARM_HEAVY; end
            7'h2B: begin a.up = ARM_HEAVY; a.down = ARM_HEAVY; a.left = ARM_HEAVY; end
            7'h33: begin a.down = ARM_HEAVY; a.left = ARM_HEAVY; a.right = ARM_HEAVY; end
            7'h3B: begin a.up = ARM_HEAVY; a.left = ARM_HEAVY; a.right = ARM_HEAVY; end
            7'h4B:
            begin
                a.up = ARM_HEAVY; a.down = ARM_HEAVY;
                a.left = ARM_HEAVY; a.right = ARM_HEAVY;
            end
            default: a.found = 1'b0;
        endcase
        return a;
    endfunction

endpackage

>>> hdl/mglyph_cover.sv
// Combinational coverage decision: is a cell pixel lit by the glyph, and is the glyph known.
module mglyph_cover
    import mglyph_pkg::*;
#(
    parameter int CELL_W = 12,
    parameter int CELL_H = 24
)
(
    input  logic [20:0] glyph_code,
    input  logic [3:0]  col_in_cell,
    input  logic [4:0]  row_in_cell,
    output logic        lit,
    output logic        recognized
);

    // Cell geometry, all settled at elaboration.
    localparam logic [6:0] WIDTH  = 7'(CELL_W);
    localparam logic [6:0] HEIGHT = 7'(CELL_H);
    localparam logic [6:0] HW     = 7'(CELL_W / 2);
    localparam logic [6:0] HH     = 7'(CELL_H / 2);
    localparam logic [6:0] HW2    = 7'(2 * (CELL_W / 2));
    localparam logic [6:0] HH2    = 7'(2 * (CELL_H / 2));
    localparam logic [6:0] ST     = 7'(CELL_H / 3);
    localparam logic [6:0] ST2    = 7'(2 * (CELL_H / 3));
    localparam logic [6:0] ST3    = 7'(3 * (CELL_H / 3));
    localparam logic [6:0] TOP_1_8   = 7'(CELL_H / 8);
    localparam logic [6:0] RIGHT_1_8 = 7'(CELL_W - (CELL_W + 4) / 8);

    // First lit row of the lower eighths blocks.
    localparam logic [6:0] LOW_1 = 7'(CELL_H - (CELL_H * 1) / 8);
    localparam logic [6:0] LOW_2 = 7'(CELL_H - (CELL_H * 2) / 8);
    localparam logic [6:0] LOW_3 = 7'(CELL_H - (CELL_H * 3) / 8);
    localparam logic [6:0] LOW_5 = 7'(CELL_H - (CELL_H * 5) / 8);
    localparam logic [6:0] LOW_6 = 7'(CELL_H - (CELL_H * 6) / 8);
    localparam logic [6:0] LOW_7 = 7'(CELL_H - (CELL_H * 7) / 8);

    // Column bound of the left eighths blocks, rounded half up.
    localparam logic [6:0] LEFT_7 = 7'((CELL_W * 7 + 4) / 8);
    localparam logic [6:0] LEFT_6 = 7'((CELL_W * 6 + 4) / 8);
    localparam logic [6:0] LEFT_5 = 7'((CELL_W * 5 + 4) / 8);
    localparam logic [6:0] LEFT_3 = 7'((CELL_W * 3 + 4) / 8);
    localparam logic [6:0] LEFT_2 = 7'((CELL_W * 2 + 4) / 8);
    localparam logic [6:0] LEFT_1 = 7'((CELL_W * 1 + 4) / 8);

    logic [6:0]  cc;
    logic [6:0]  rr;
    logic        in_cell;
    logic        in_sext;
    logic        in_block;
    logic        in_box;
    box_arms_t   arms;
    logic        box_hit;
    logic        block_hit;
    logic        sext_hit;
    logic        q_left;
    logic        q_right;
    logic        q_top;
    logic        q_bot;
    logic [3:0]  quad_cover;
    logic [20:0] sext_off;
    logic [6:0]  mask_a;
    logic [6:0]  mask_b;
    logic [6:0]  mask_c;
    logic [1:0]  sext_band;
    logic [2:0]  sext_bit;

    // Low and high edge of an arm band around a cell center line.
    function automatic logic [6:0] band_lo(input logic [6:0] ctr, input arm_weight_t wt);
        return ctr - ((wt == ARM_HEAVY) ? 7'd2 : 7'd1);
    endfunction

    function automatic logic [6:0] band_hi(input logic [6:0] ctr, input arm_weight_t wt);
        return ctr + ((wt == ARM_HEAVY) ? 7'd2 : 7'd1);
    endfunction

    assign cc      = {3'b000, col_in_cell};
    assign rr      = {2'b00, row_in_cell};
    assign in_cell = (cc < WIDTH) && (rr < HEIGHT);

    // Which glyph set the codepoint falls in.
    assign in_sext  = (glyph_code >= SEXT_FIRST) && (glyph_code <= SEXT_LAST);
    assign in_block = (glyph_code >= BLOCK_FIRST) && (glyph_code <= BLOCK_LAST);
    assign in_box   = (glyph_code >= BOX_FIRST) && (glyph_code <= BOX_LAST);
    assign arms     = box_lookup(glyph_code[6:0]);

    // Box drawing: each present arm is a band through the cell center.
    always_comb
    begin
        box_hit = 1'b0;
        if (arms.up != ARM_NONE && cc >= band_lo(HW, arms.up) && cc < band_hi(HW, arms.up)
            && rr < band_hi(HH, arms.up))
            box_hit = 1'b1;
        if (arms.down != ARM_NONE && cc >= band_lo(HW, arms.down)
            && cc < band_hi(HW, arms.down) && rr >= band_lo(HH, arms.down))
            box_hit = 1'b1;
        if (arms.left != ARM_NONE && rr >= band_lo(HH, arms.left)
            && rr < band_hi(HH, arms.left) && cc < band_hi(HW, arms.left))
            box_hit = 1'b1;
        if (arms.right != ARM_NONE && rr >= band_lo(HH, arms.right)
            && rr < band_hi(HH, arms.right) && cc >= band_lo(HW, arms.right))
            box_hit = 1'b1;
    end

    // Quadrant membership of the pixel.
    assign q_left  = cc < HW;
    assign q_right = (cc >= HW) && (cc < HW2);
    assign q_top   = rr < HH;
    assign q_bot   = (rr >= HH) && (rr < HH2);
    assign quad_cover = {q_right & q_bot, q_left & q_bot, q_right & q_top, q_left & q_top};

    // Block elements.
    always_comb
    begin
        unique case (blk_code_t'(glyph_code[4:0]))
            BLK_UPPER_HALF:    block_hit = rr < HH;
            BLK_LOWER_HALF:    block_hit = (rr >= HH) && (rr < HH2);
            BLK_FULL:          block_hit = 1'b1;
            BLK_LEFT_HALF:     block_hit = cc < HW;
            BLK_RIGHT_HALF:    block_hit = (cc >= HW) && (cc < HW2);
            BLK_LOWER_1_8:     block_hit = rr >= LOW_1;
            BLK_LOWER_1_4:     block_hit = rr >= LOW_2;
            BLK_LOWER_3_8:     block_hit = rr >= LOW_3;
            BLK_LOWER_5_8:     block_hit = rr >= LOW_5;
            BLK_LOWER_3_4:     block_hit = rr >= LOW_6;
            BLK_LOWER_7_8:     block_hit = rr >= LOW_7;
            BLK_LEFT_7_8:      block_hit = cc < LEFT_7;
            BLK_LEFT_3_4:      block_hit = cc < LEFT_6;
            BLK_LEFT_5_8:      block_hit = cc < LEFT_5;
            BLK_LEFT_3_8:      block_hit = cc < LEFT_3;
            BLK_LEFT_1_4:      block_hit = cc < LEFT_2;
            BLK_LEFT_1_8:      block_hit = cc < LEFT_1;
            BLK_SHADE_LIGHT:   block_hit = BAYER2[row_in_cell[0]][col_in_cell[0]] < 2'd1;
            BLK_SHADE_MEDIUM:  block_hit = (col_in_cell[0] ^ row_in_cell[0]) == 1'b0;
            BLK_SHADE_DARK:    block_hit = BAYER2[row_in_cell[0]][col_in_cell[0]] < 2'd3;
            BLK_UPPER_1_8:     block_hit = rr < TOP_1_8;
            BLK_RIGHT_1_8:     block_hit = cc >= RIGHT_1_8;
            BLK_QUAD_LL:       block_hit = |(quad_cover & QUAD_LL);
            BLK_QUAD_LR:       block_hit = |(quad_cover & QUAD_LR);
            BLK_QUAD_UL:       block_hit = |(quad_cover & QUAD_UL);
            BLK_QUAD_UL_LL_LR: block_hit = |(quad_cover & (QUAD_UL | QUAD_LL | QUAD_LR));
            BLK_QUAD_UL_LR:    block_hit = |(quad_cover & (QUAD_UL | QUAD_LR));
            BLK_QUAD_UL_UR_LL: block_hit = |(quad_cover & (QUAD_UL | QUAD_UR | QUAD_LL));
            BLK_QUAD_UL_UR_LR: block_hit = |(quad_cover & (QUAD_UL | QUAD_UR | QUAD_LR));
            BLK_QUAD_UR:       block_hit = |(quad_cover & QUAD_UR);
            BLK_QUAD_UR_LL:    block_hit = |(quad_cover & (QUAD_UR | QUAD_LL));
            BLK_QUAD_UR_LL_LR: block_hit = |(quad_cover & (QUAD_UR | QUAD_LL | QUAD_LR));
            default:           block_hit = 1'b0;
        endcase
    end

    // Sextants: the codepoint offset maps to a 6-bit mask with two masks skipped.
    assign sext_off = glyph_code - SEXT_FIRST;
    assign mask_a   = {1'b0, sext_off[5:0]} + 7'd1;
    assign mask_b   = (mask_a >= SEXT_SKIP_LO) ? mask_a + 7'd1 : mask_a;
    assign mask_c   = (mask_b >= SEXT_SKIP_HI) ? mask_b + 7'd1 : mask_b;

    // Row band of the 2x3 grid, then the bit index within the mask.
    always_comb
    begin
        priority if (rr < ST)
            sext_band = 2'd0;
        else if (rr < ST2)
            sext_band = 2'd1;
        else
            sext_band = 2'd2;
    end

    assign sext_bit = {sext_band, (cc >= HW) ? 1'b1 : 1'b0};
    assign sext_hit = (cc < HW2) && (rr < ST3) && mask_c[sext_bit];

    // Final selection across the glyph sets.
    always_comb
    begin
        priority if (in_sext)
        begin
            recognized = 1'b1;
            lit        = in_cell && sext_hit;
        end
        else if (in_block)
        begin
            recognized = 1'b1;
            lit        = in_cell && block_hit;
        end
        else
        begin
            recognized = in_box && arms.found;
            lit        = in_box && arms.found && in_cell && box_hit;
        end
    end

endmodule

>>> hdl/mosaic_glyph_pixel_generator_core.sv
// Top level of the mosaic glyph pixel generator: input register, coverage logic, result register.
//
// Each transaction names one pixel of a character cell and a glyph codepoint; the block
// answers whether that pixel is lit by a box drawing, block element or sextant glyph.
// A transaction is taken at every clock edge where start is high (busy is always low),
// so one pixel per clock is sustained. The start edge loads the input register, and the
// result register captures the answer of the combinational coverage logic for that pixel;
// the result is shown on result_valid for exactly one cycle. The receiver cannot stall the block,
// so results must be taken in the cycle they are shown.
module mosaic_glyph_pixel_generator_core
    import mglyph_pkg::*;
#(
    parameter int CELL_W = 12,
    parameter int CELL_H = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [20:0] glyph_code,
    input  logic [10:0] cell_x,
    input  logic [10:0] cell_y,
    input  logic [3:0]  col_in_cell,
    input  logic [4:0]  row_in_cell,
    input  logic [7:0]  ink_in,
    output logic        result_valid,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic        lit,
    output logic [7:0]  ink_out,
    output logic        recognized
);

    logic        in_valid_reg;
    logic [20:0] code_reg;
    logic [10:0] cell_x_reg;
    logic [10:0] cell_y_reg;
    logic [3:0]  col_reg;
    logic [4:0]  row_reg;
    logic [7:0]  ink_reg;

    logic        out_valid_reg;
    logic [11:0] pixel_x_reg;
    logic [11:0] pixel_y_reg;
    logic        lit_reg;
    logic [7:0]  ink_out_reg;
    logic        recognized_reg;

    logic        lit_next;
    logic        recognized_next;
    logic [11:0] pixel_x_next;
    logic [11:0] pixel_y_next;

    // The pipeline never backs up.
    assign busy = 1'b0;

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            code_reg   <= glyph_code;
            cell_x_reg <= cell_x;
            cell_y_reg <= cell_y;
            col_reg    <= col_in_cell;
            row_reg    <= row_in_cell;
            ink_reg    <= ink_in;
        end
    end

    // Glyph coverage for the registered pixel.
    mglyph_cover #(
        .CELL_W (CELL_W),
        .CELL_H (CELL_H)
    ) u_cover (
        .glyph_code  (code_reg),
        .col_in_cell (col_reg),
        .row_in_cell (row_reg),
        .lit         (lit_next),
        .recognized  (recognized_next)
    );

    // Absolute pixel position.
    assign pixel_x_next = {1'b0, cell_x_reg} + {8'd0, col_reg};
    assign pixel_y_next = {1'b0, cell_y_reg} + {7'd0, row_reg};

    // Result stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= in_valid_reg;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            pixel_x_reg    <= pixel_x_next;
            pixel_y_reg    <= pixel_y_next;
            lit_reg        <= lit_next;
            ink_out_reg    <= ink_reg;
            recognized_reg <= recognized_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign lit          = lit_reg;
    assign ink_out      = ink_out_reg;
    assign recognized   = recognized_reg;

endmodule

>>> hdl/mglyph_checker.sv
// Port-level assertions for the mosaic glyph pixel generator, bound to the top level.
module mglyph_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [20:0] glyph_code,
    input  logic [10:0] cell_x,
    input  logic [10:0] cell_y,
    input  logic [3:0]  col_in_cell,
    input  logic [4:0]  row_in_cell,
    input  logic [7:0]  ink_in,
    input  logic        result_valid,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic        lit,
    input  logic [7:0]  ink_out,
    input  logic        recognized
);

    // Every accepted transaction yields a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("accepted transaction produced no result");

    // No result without an earlier accepted transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    // The pixel position is the sum of cell origin and offset of that transaction.
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pixel_x == ({1'b0, $past(cell_x, 2)} + {8'd0, $past(col_in_cell, 2)}))
                      && (pixel_y == ({1'b0, $past(cell_y, 2)} + {7'd0, $past(row_in_cell, 2)})))
        else $error("pixel position does not match the transaction");

    // Ink travels with its transaction, and only a known glyph lights a pixel.
    a_ink_and_lit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (ink_out == $past(ink_in, 2)) && (!lit || recognized))
        else $error("ink mismatch or lit pixel for an unknown glyph");

endmodule

bind mosaic_glyph_pixel_generator_core mglyph_checker u_mglyph_checker (.*);
